FILE: rtl/encoder_speed_pid_pwm_defines.svh
// Assertion macros shared by the encoder speed PID PWM RTL.
`ifndef ENCODER_SPEED_PID_PWM_DEFINES_SVH
`define ENCODER_SPEED_PID_PWM_DEFINES_SVH

// Immediate-cycle check, gated by reset.
`define ESPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check in the cycle after a trigger, gated by reset.
`define ESPP_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error(msg);

`endif

FILE: rtl/espp_pkg.sv
// Shared types and constants for the encoder speed PID PWM block.
`timescale 1ns / 1ps
package espp_pkg;

  localparam int COUNT_WIDTH    = 20;
  localparam int GAIN_FRAC_BITS = 16;

  localparam int SPEED_W    = 23;
  localparam int ERR_W      = SPEED_W + 1;
  localparam int SUM_W      = 32;
  localparam int GAIN_W     = 24;
  localparam int DUTY_W     = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam int SPD_RAW_W  = (COUNT_WIDTH + 3 > SPEED_W + 1) ? COUNT_WIDTH + 3 : SPEED_W + 1;
  localparam int PROD_PD_W  = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W   = GAIN_W + 1 + SUM_W;
  localparam int ACC_W      = PROD_I_W + 1;
  localparam int DRV_W      = ACC_W - GAIN_FRAC_BITS + 1;

  localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};
  localparam logic [ACC_W-1:0]   RND_BIAS  =
    {{(ACC_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

  typedef enum logic [1:0] {
    CMD_EDGE   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_PWM    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_KP     = 3'd1,
    REG_KI     = 3'd2,
    REG_KD     = 3'd3,
    REG_FF     = 3'd4,
    REG_DIR    = 3'd5,
    REG_PERIOD = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_acc;
    logic ld_drv;
  } pid_ctrl_t;

endpackage

FILE: rtl/encoder_speed_pid_pwm.sv
// Top level: encoder speed PID loop with PWM output, item pipeline and config.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid/in_ready   | in_cmd, in_b_level
//  out      | out_valid/out_ready | out_pwm_level, out_direction_level,
//           |                     | out_duty, out_speed
//  cfg      | cfg_we (no wait)    | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; every item yields one result,
// registered in turn through input reg, front stage, multiply, accumulate, scale, output.
// The six-deep pipeline is set by the three gain multipliers and the wide sum.
// Reset clears all loop state and loads the register defaults; no clearing pass.
// A stalled output backs the pipeline up one stage at a time; bubbles collapse,
// so input keeps flowing until every stage holds an item.
`timescale 1ns / 1ps
`include "encoder_speed_pid_pwm_defines.svh"
module encoder_speed_pid_pwm import espp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_cmd,
  input  logic                   in_b_level,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_pwm_level,
  output logic                   out_direction_level,
  output logic [DUTY_W-1:0]      out_duty,
  output logic [SPEED_W-1:0]     out_speed,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // ---------------- configuration registers ----------------
  logic [SPEED_W-1:0] cfg_target_r;
  logic [GAIN_W-1:0]  cfg_kp_r, cfg_ki_r, cfg_kd_r;
  logic [DUTY_W-1:0]  cfg_ff_r, cfg_period_r;
  logic               cfg_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_target_r <= SPEED_W'(300);
      cfg_kp_r     <= GAIN_W'(262144);
      cfg_ki_r     <= GAIN_W'(3932);
      cfg_kd_r     <= GAIN_W'(65536);
      cfg_ff_r     <= DUTY_W'(569);
      cfg_dir_r    <= 1'b0;
      cfg_period_r <= DUTY_W'(5000);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_TARGET: cfg_target_r <= cfg_data[SPEED_W-1:0];
        REG_KP:     cfg_kp_r     <= cfg_data[GAIN_W-1:0];
        REG_KI:     cfg_ki_r     <= cfg_data[GAIN_W-1:0];
        REG_KD:     cfg_kd_r     <= cfg_data[GAIN_W-1:0];
        REG_FF:     cfg_ff_r     <= cfg_data[DUTY_W-1:0];
        REG_DIR:    cfg_dir_r    <= cfg_data[0];
        REG_PERIOD: cfg_period_r <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline flow control ----------------
  // Stage k loads when it is empty or its item moves on this cycle.
  logic v0_r, v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic ld1, ld2, ld3, ld4, ld_o;
  logic in_acc, out_acc;

  assign rdy_o = !out_valid_r || out_ready;
  assign rdy4  = !v4_r || rdy_o;
  assign rdy3  = !v3_r || rdy4;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign rdy0  = !v0_r || rdy1;

  assign ld1   = v0_r && rdy1;
  assign ld2   = v1_r && rdy2;
  assign ld3   = v2_r && rdy3;
  assign ld4   = v3_r && rdy4;
  assign ld_o  = v4_r && rdy_o;

  assign in_ready = rdy0;
  assign in_acc   = in_valid && rdy0;
  assign out_acc  = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0)  v0_r        <= in_valid;
      if (rdy1)  v1_r        <= v0_r;
      if (rdy2)  v2_r        <= v1_r;
      if (rdy3)  v3_r        <= v2_r;
      if (rdy4)  v4_r        <= v3_r;
      if (rdy_o) out_valid_r <= v4_r;
    end
  end

  // item payload traveling alongside the PID datapath
  cmd_t               cmd0_r, cmd1_r, cmd2_r, cmd3_r, cmd4_r;
  logic               b0_r;
  logic [SPEED_W-1:0] spd2_r, spd3_r, spd4_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd0_r <= cmd_t'(in_cmd);
      b0_r   <= in_b_level;
    end
    if (ld1) cmd1_r <= cmd0_r;
    if (ld2) cmd2_r <= cmd1_r;
    if (ld3) cmd3_r <= cmd2_r;
    if (ld4) cmd4_r <= cmd3_r;
  end

  // ---------------- encoder / sampling front ----------------
  logic signed [ERR_W-1:0] fr_err, fr_delta;
  logic signed [SUM_W-1:0] fr_sum;
  logic [SPEED_W-1:0]      fr_speed;

  espp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .ld           (ld1),
    .cmd          (cmd0_r),
    .b_level      (b0_r),
    .target_speed (cfg_target_r),
    .err          (fr_err),
    .err_sum      (fr_sum),
    .delta        (fr_delta),
    .speed        (fr_speed)
  );

  always_ff @(posedge clk) begin
    if (ld2) spd2_r <= fr_speed;
    if (ld3) spd3_r <= spd2_r;
    if (ld4) spd4_r <= spd3_r;
  end

  // ---------------- PID datapath ----------------
  pid_ctrl_t               pid_ctl;
  logic signed [DRV_W-1:0] drive;

  assign pid_ctl.ld_mul = ld2;
  assign pid_ctl.ld_acc = ld3;
  assign pid_ctl.ld_drv = ld4;

  espp_pid u_pid (
    .clk          (clk),
    .ctl          (pid_ctl),
    .kp           (cfg_kp_r),
    .ki_dt        (cfg_ki_r),
    .kd_dt        (cfg_kd_r),
    .feed_forward (cfg_ff_r),
    .err          (fr_err),
    .err_sum      (fr_sum),
    .delta        (fr_delta),
    .drive        (drive)
  );

  // ---------------- duty clamp and PWM counter (output stage) ----------------
  logic [DUTY_W-1:0]       duty_r, duty_nxt, duty_clamp;
  logic [DUTY_W-1:0]       cnt_r, cnt_nxt, act_r, act_nxt;
  logic [DUTY_W:0]         cnt_inc;
  logic signed [DRV_W-1:0] period_s;

  assign period_s = $signed(DRV_W'(cfg_period_r));

  always_comb begin
    if (drive < $signed(DRV_W'(0))) begin
      duty_clamp = '0;
    end else if (drive > period_s) begin
      duty_clamp = cfg_period_r;
    end else begin
      duty_clamp = drive[DUTY_W-1:0];
    end
  end

  // a counter at or past the period (also after the period shrinks) wraps to 0
  assign cnt_inc = {1'b0, cnt_r} + (DUTY_W+1)'(1);

  always_comb begin
    duty_nxt = duty_r;
    cnt_nxt  = cnt_r;
    act_nxt  = act_r;
    case (cmd4_r)
      CMD_SAMPLE: duty_nxt = duty_clamp;
      CMD_PWM: begin
        cnt_nxt = (cnt_inc >= {1'b0, cfg_period_r}) ? '0 : cnt_inc[DUTY_W-1:0];
        if (cnt_nxt == '0) act_nxt = duty_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= '0;
      cnt_r  <= '0;
      act_r  <= '0;
    end else if (ld_o) begin
      duty_r <= duty_nxt;
      cnt_r  <= cnt_nxt;
      act_r  <= act_nxt;
    end
  end

  // result register
  logic               out_pwm_r, out_dir_r;
  logic [DUTY_W-1:0]  out_duty_r;
  logic [SPEED_W-1:0] out_speed_r;

  always_ff @(posedge clk) begin
    if (ld_o) begin
      out_pwm_r   <= cnt_nxt < act_nxt;
      out_dir_r   <= cfg_dir_r;
      out_duty_r  <= duty_nxt;
      out_speed_r <= spd4_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pwm_level       = out_pwm_r;
  assign out_direction_level = out_dir_r;
  assign out_duty            = out_duty_r;
  assign out_speed           = out_speed_r;

  // ---------------- assertions ----------------
  logic [5:0] vld_vec;
  logic [2:0] n_vld;
  logic       out_stall, smp_o, wrap_o;
  assign vld_vec   = {v0_r, v1_r, v2_r, v3_r, v4_r, out_valid_r};
  assign n_vld     = 3'($countones(vld_vec));
  assign out_stall = out_valid_r && !out_ready;
  assign smp_o     = ld_o && (cmd4_r == CMD_SAMPLE);
  assign wrap_o    = ld_o && (cmd4_r == CMD_PWM) && (cnt_nxt == '0);

  `ESPP_ASSERT(a_full_when_blocked, !in_ready |-> out_stall, "input blocked, no output stall")
  `ESPP_ASSERT_NEXT(a_items, rst_n, n_vld == $past(n_vld + in_acc - out_acc), "item count off")
  `ESPP_ASSERT_NEXT(a_duty_clamp, smp_o, out_duty_r <= $past(cfg_period_r), "duty above period")
  `ESPP_ASSERT_NEXT(a_duty_latch, wrap_o, act_r == duty_r, "duty not latched at wrap")

endmodule

FILE: rtl/espp_front.sv
// Encoder window counter, speed sampling and error integration.
`timescale 1ns / 1ps
module espp_front import espp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ld,
  input  cmd_t                     cmd,
  input  logic                     b_level,
  input  logic [SPEED_W-1:0]       target_speed,
  output logic signed [ERR_W-1:0]  err,
  output logic signed [SUM_W-1:0]  err_sum,
  output logic signed [ERR_W-1:0]  delta,
  output logic [SPEED_W-1:0]       speed
);

  localparam logic signed [COUNT_WIDTH-1:0] CNT_LIM   = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_LIM_N = -CNT_LIM;
  localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE   = COUNT_WIDTH'(1);
  localparam logic signed [SUM_W-1:0]       SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]       SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

  logic signed [COUNT_WIDTH-1:0] window_r, window_nxt, window_neg;
  logic [SPEED_W-1:0]            last_speed_r, last_speed_nxt;
  logic signed [SUM_W-1:0]       err_sum_r, err_sum_nxt;

  logic [COUNT_WIDTH-2:0]        mag;
  logic [SPD_RAW_W-1:0]          mag_x, spd_raw;
  logic [SPEED_W-1:0]            speed_now;
  logic signed [ERR_W-1:0]       err_now, delta_now;
  logic signed [SUM_W:0]         sum_wide;
  logic signed [SUM_W-1:0]       sum_sat;

  logic signed [ERR_W-1:0]       err_r, delta_r;
  logic signed [SUM_W-1:0]       sum_out_r;
  logic [SPEED_W-1:0]            speed_r;

  // speed = 10 * |count|, saturated to the speed field
  assign window_neg = -window_r;
  assign mag        = window_r[COUNT_WIDTH-1] ? window_neg[COUNT_WIDTH-2:0]
                                              : window_r[COUNT_WIDTH-2:0];
  assign mag_x      = SPD_RAW_W'(mag);
  assign spd_raw    = (mag_x << 3) + (mag_x << 1);
  assign speed_now  = (spd_raw > SPD_RAW_W'(SPEED_MAX)) ? SPEED_MAX : spd_raw[SPEED_W-1:0];

  assign err_now    = $signed({1'b0, target_speed}) - $signed({1'b0, speed_now});
  assign delta_now  = $signed({1'b0, speed_now}) - $signed({1'b0, last_speed_r});
  assign sum_wide   = (SUM_W+1)'(err_sum_r) + (SUM_W+1)'(err_now);

  always_comb begin
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
  end

  always_comb begin
    window_nxt     = window_r;
    last_speed_nxt = last_speed_r;
    err_sum_nxt    = err_sum_r;
    case (cmd)
      CMD_EDGE: begin
        if (b_level) begin
          if (window_r < CNT_LIM) window_nxt = window_r + CNT_ONE;
        end else begin
          if (window_r > CNT_LIM_N) window_nxt = window_r - CNT_ONE;
        end
      end
      CMD_SAMPLE: begin
        window_nxt     = '0;
        last_speed_nxt = speed_now;
        err_sum_nxt    = sum_sat;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r     <= '0;
      last_speed_r <= '0;
      err_sum_r    <= '0;
    end else if (ld) begin
      window_r     <= window_nxt;
      last_speed_r <= last_speed_nxt;
      err_sum_r    <= err_sum_nxt;
    end
  end

  // stage register toward the multipliers
  always_ff @(posedge clk) begin
    if (ld) begin
      err_r     <= err_now;
      sum_out_r <= err_sum_nxt;
      delta_r   <= delta_now;
      speed_r   <= last_speed_nxt;
    end
  end

  assign err     = err_r;
  assign err_sum = sum_out_r;
  assign delta   = delta_r;
  assign speed   = speed_r;

endmodule

FILE: rtl/espp_pid.sv
// PID datapath: gain products, accumulate, scale toward zero, add feed-forward.
`timescale 1ns / 1ps
module espp_pid import espp_pkg::*; (
  input  logic                     clk,
  input  pid_ctrl_t                ctl,
  input  logic [GAIN_W-1:0]        kp,
  input  logic [GAIN_W-1:0]        ki_dt,
  input  logic [GAIN_W-1:0]        kd_dt,
  input  logic [DUTY_W-1:0]        feed_forward,
  input  logic signed [ERR_W-1:0]  err,
  input  logic signed [SUM_W-1:0]  err_sum,
  input  logic signed [ERR_W-1:0]  delta,
  output logic signed [DRV_W-1:0]  drive
);

  logic signed [PROD_PD_W-1:0] prod_p_nxt, prod_d_nxt, prod_p_r, prod_d_r;
  logic signed [PROD_I_W-1:0]  prod_i_nxt, prod_i_r;
  logic signed [ACC_W-1:0]     acc_nxt, acc_r, acc_biased;
  logic signed [DRV_W-2:0]     drv_sh;
  logic signed [DRV_W-1:0]     drive_nxt, drive_r;

  assign prod_p_nxt = $signed({1'b0, kp}) * err;
  assign prod_i_nxt = $signed({1'b0, ki_dt}) * err_sum;
  assign prod_d_nxt = $signed({1'b0, kd_dt}) * delta;

  assign acc_nxt = ACC_W'(prod_p_r) + ACC_W'(prod_i_r) + ACC_W'(prod_d_r);

  // arithmetic shift rounds down; bias negatives so the result truncates toward zero
  assign acc_biased = acc_r + (acc_r[ACC_W-1] ? $signed(RND_BIAS) : $signed(ACC_W'(0)));
  assign drv_sh     = acc_biased[ACC_W-1:GAIN_FRAC_BITS];
  assign drive_nxt  = DRV_W'(drv_sh) + $signed(DRV_W'(feed_forward));

  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
      prod_d_r <= prod_d_nxt;
    end
    if (ctl.ld_acc) acc_r   <= acc_nxt;
    if (ctl.ld_drv) drive_r <= drive_nxt;
  end

  assign drive = drive_r;

endmodule
